// File: src/fcwm_pkg.sv
// Shared types, constants and helpers for the four-character word machine.
// No dependencies; used by the interfaces, the memory and the top level.
`default_nettype none

package fcwm_pkg;

  localparam int unsigned MEM_WORDS_DEF   = 100;
  localparam int unsigned PRINT_WORDS_DEF = 10;

  localparam int ADDR_W = 7;
  localparam int WORD_W = 32;
  localparam int CNT_W  = 3;
  localparam int KIND_W = 3;
  localparam int CMD_W  = 2;

  localparam logic [WORD_W-1:0] SPACES = 32'h2020_2020;

  localparam logic [7:0] CH_UNDER = 8'h5F;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_G     = 8'h47;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_L     = 8'h4C;
  localparam logic [7:0] CH_S     = 8'h53;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_B     = 8'h42;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_D     = 8'h44;

  typedef enum logic [CMD_W-1:0] {
    CMD_WRITE = 2'd0,
    CMD_EXEC  = 2'd1,
    CMD_START = 2'd2,
    CMD_INIT  = 2'd3
  } cmd_e;

  typedef enum logic [KIND_W-1:0] {
    K_DONE  = 3'd0,
    K_REQ   = 3'd1,
    K_PRINT = 3'd2,
    K_HALT  = 3'd3,
    K_ERR   = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_FETCH,
    S_DECODE,
    S_EXEC,
    S_OUT
  } state_e;

  typedef struct packed {
    logic              clr;
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [WORD_W-1:0] wdata;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // characters before the first underscore
  function automatic logic [CNT_W-1:0] count_chars(input logic [WORD_W-1:0] w);
    logic [CNT_W-1:0] n;
    logic             hit;
    n   = '0;
    hit = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!hit && (w[WORD_W-1-8*i -: 8] == CH_UNDER)) begin
        hit = 1'b1;
      end else if (!hit) begin
        n = n + 3'd1;
      end
    end
    return n;
  endfunction

endpackage

`default_nettype wire

// File: src/fcwm_if.sv
// Valid/ready channel interfaces for command items and result items.
// Depends on fcwm_pkg for field widths.
`default_nettype none

interface fcwm_in_if;
  logic                      valid;
  logic                      ready;
  logic [fcwm_pkg::CMD_W-1:0]  cmd;
  logic [fcwm_pkg::ADDR_W-1:0] address;
  logic [fcwm_pkg::WORD_W-1:0] word_in;

  modport source (output valid, output cmd, output address, output word_in, input ready);
  modport sink   (input valid, input cmd, input address, input word_in, output ready);
endinterface

interface fcwm_out_if;
  logic                        valid;
  logic                        ready;
  logic [fcwm_pkg::KIND_W-1:0] kind;
  logic [fcwm_pkg::ADDR_W-1:0] target;
  logic [fcwm_pkg::WORD_W-1:0] word_out;
  logic [fcwm_pkg::CNT_W-1:0]  char_count;
  logic                        toggle_out;
  logic                        last;

  modport source (output valid, output kind, output target, output word_out,
                  output char_count, output toggle_out, output last, input ready);
  modport sink   (input valid, input kind, input target, input word_out,
                  input char_count, input toggle_out, input last, output ready);
endinterface

`default_nettype wire

// File: src/fcwm_mem.sv
// Word memory: one write and one registered read port, per-word valid flags.
// A word never written since reset or init reads as four spaces. Uses fcwm_pkg.
`default_nettype none

module fcwm_mem #(
  parameter int unsigned MEM_WORDS = fcwm_pkg::MEM_WORDS_DEF
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire fcwm_pkg::mem_req_t          req_i,
  output logic [fcwm_pkg::WORD_W-1:0]      rdata_o
);
  import fcwm_pkg::*;

  localparam int AW = $clog2(MEM_WORDS);

  logic [WORD_W-1:0]    mem [MEM_WORDS];
  logic [MEM_WORDS-1:0] vld_q;
  logic [WORD_W-1:0]    rdata_q;
  logic                 rvld_q;

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr[AW-1:0]] <= req_i.wdata;
    end
    rdata_q <= mem[req_i.raddr[AW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      rvld_q <= vld_q[req_i.raddr[AW-1:0]];
      if (req_i.clr) begin
        vld_q <= '0;
      end else if (req_i.we) begin
        vld_q[req_i.waddr[AW-1:0]] <= 1'b1;
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : SPACES;

endmodule

`default_nettype wire

// File: src/four_char_word_machine_core_unit.sv
// Four-character word machine core: sequencer around one word memory.
// Write, start, init and a step that is halted or past the end go from idle straight to
// the result; other steps pass fetch and decode, and LR, CR and PD also pass exec for the
// registered memory read. PD then reads each next word in exec after the previous one
// is taken. One item at a time; ready only when idle.
// Reset (and init) clears registers and marks every word as four spaces.
`default_nettype none

module four_char_word_machine_core_unit #(
  parameter int unsigned MEM_WORDS   = fcwm_pkg::MEM_WORDS_DEF,
  parameter int unsigned PRINT_WORDS = fcwm_pkg::PRINT_WORDS_DEF
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  fcwm_in_if.sink     in_i,
  fcwm_out_if.source  out_o
);
  import fcwm_pkg::*;

  localparam logic [ADDR_W-1:0] MEM_LIM = ADDR_W'(MEM_WORDS);
  localparam logic [ADDR_W-1:0] PRT_N   = ADDR_W'(PRINT_WORDS);

  state_e            state_q, state_d;
  logic [ADDR_W-1:0] pc_q, pc_d;
  logic              tog_q, tog_d;
  logic              halt_q, halt_d;
  logic [WORD_W-1:0] gen_q, gen_d;
  logic [WORD_W-1:0] ir_q, ir_d;
  logic [ADDR_W-1:0] pa_q, pa_d;
  logic [ADDR_W-1:0] pend_q, pend_d;

  kind_e             kind_q, kind_d;
  logic [ADDR_W-1:0] tgt_q, tgt_d;
  logic [WORD_W-1:0] wout_q, wout_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              last_q, last_d;

  mem_req_t          mreq;
  logic [WORD_W-1:0] rdata;

  logic [7:0]        c0, c1, d2, d3;
  logic [3:0]        d2n, d3n;
  logic [ADDR_W-1:0] addr;
  logic              uses_addr, digits_ok;

  fcwm_mem #(.MEM_WORDS(MEM_WORDS)) u_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (mreq),
    .rdata_o (rdata)
  );

  // instruction decode
  assign c0  = ir_q[31:24];
  assign c1  = ir_q[23:16];
  assign d2  = ir_q[15:8];
  assign d3  = ir_q[7:0];
  assign d2n = d2[3:0] - CH_ZERO[3:0];
  assign d3n = d3[3:0] - CH_ZERO[3:0];
  assign addr = ({3'b000, d2n} << 3) + ({3'b000, d2n} << 1) + {3'b000, d3n};
  assign digits_ok = (d2 >= CH_ZERO) && (d2 <= CH_NINE) && (d3 >= CH_ZERO) && (d3 <= CH_NINE);
  assign uses_addr = ((c1 == CH_D) && ((c0 == CH_G) || (c0 == CH_P))) ||
                     ((c1 == CH_R) && ((c0 == CH_L) || (c0 == CH_S) || (c0 == CH_C))) ||
                     ((c0 == CH_B) && (c1 == CH_T));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pc_q    <= '0;
      tog_q   <= 1'b0;
      halt_q  <= 1'b0;
      gen_q   <= SPACES;
      ir_q    <= SPACES;
    end else begin
      state_q <= state_d;
      pc_q    <= pc_d;
      tog_q   <= tog_d;
      halt_q  <= halt_d;
      gen_q   <= gen_d;
      ir_q    <= ir_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pa_q   <= pa_d;
    pend_q <= pend_d;
    kind_q <= kind_d;
    tgt_q  <= tgt_d;
    wout_q <= wout_d;
    cnt_q  <= cnt_d;
    last_q <= last_d;
  end

  always_comb begin
    state_d = state_q;
    pc_d    = pc_q;
    tog_d   = tog_q;
    halt_d  = halt_q;
    gen_d   = gen_q;
    ir_d    = ir_q;
    pa_d    = pa_q;
    pend_d  = pend_q;
    kind_d  = kind_q;
    tgt_d   = tgt_q;
    wout_d  = wout_q;
    cnt_d   = cnt_q;
    last_d  = last_q;
    mreq    = '0;

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          kind_d  = K_DONE;
          tgt_d   = '0;
          wout_d  = '0;
          cnt_d   = '0;
          last_d  = 1'b1;
          state_d = S_OUT;
          case (cmd_e'(in_i.cmd))
            CMD_WRITE: begin
              if (in_i.address >= MEM_LIM) begin
                kind_d = K_ERR;
              end else begin
                mreq.we    = 1'b1;
                mreq.waddr = in_i.address;
                mreq.wdata = in_i.word_in;
              end
            end
            CMD_EXEC: begin
              if (halt_q) begin
                kind_d = K_HALT;
              end else if (pc_q >= MEM_LIM) begin
                kind_d = K_ERR;
              end else begin
                mreq.raddr = pc_q;
                state_d    = S_FETCH;
              end
            end
            CMD_START: begin
              pc_d   = '0;
              halt_d = 1'b0;
            end
            default: begin
              mreq.clr = 1'b1;
              gen_d    = SPACES;
              ir_d     = SPACES;
              pc_d     = '0;
              tog_d    = 1'b0;
              halt_d   = 1'b0;
            end
          endcase
        end
      end

      S_FETCH: begin
        ir_d    = rdata;
        pc_d    = pc_q + 7'd1;
        state_d = S_DECODE;
      end

      S_DECODE: begin
        state_d = S_OUT;
        if ((c0 == CH_H) && (c1 == CH_SPACE)) begin
          halt_d = 1'b1;
          kind_d = K_HALT;
        end else if (!uses_addr) begin
          kind_d = K_DONE;
        end else if (!digits_ok) begin
          kind_d = K_ERR;
        end else if (c0 == CH_P) begin
          if (({1'b0, addr} + {1'b0, PRT_N}) > {1'b0, MEM_LIM}) begin
            kind_d = K_ERR;
          end else begin
            pa_d       = addr;
            pend_d     = addr + PRT_N - 7'd1;
            mreq.raddr = addr;
            state_d    = S_EXEC;
          end
        end else if (addr >= MEM_LIM) begin
          kind_d = K_ERR;
        end else if (c0 == CH_G) begin
          kind_d = K_REQ;
          tgt_d  = addr;
        end else if ((c0 == CH_L) || (c0 == CH_C)) begin
          mreq.raddr = addr;
          state_d    = S_EXEC;
        end else if (c0 == CH_S) begin
          mreq.we    = 1'b1;
          mreq.waddr = addr;
          mreq.wdata = gen_q;
        end else if (tog_q) begin
          pc_d  = addr;
          tog_d = 1'b0;
        end
      end

      S_EXEC: begin
        state_d = S_OUT;
        if (c0 == CH_L) begin
          gen_d = rdata;
        end else if (c0 == CH_C) begin
          tog_d = (gen_q == rdata);
        end else begin
          kind_d = K_PRINT;
          tgt_d  = pa_q;
          wout_d = rdata;
          cnt_d  = count_chars(rdata);
          last_d = (pa_q == pend_q);
        end
      end

      S_OUT: begin
        if (out_o.ready) begin
          if (!last_q) begin
            pa_d       = pa_q + 7'd1;
            mreq.raddr = pa_q + 7'd1;
            state_d    = S_EXEC;
          end else begin
            state_d = S_IDLE;
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  assign in_i.ready       = (state_q == S_IDLE);
  assign out_o.valid      = (state_q == S_OUT);
  assign out_o.kind       = kind_q;
  assign out_o.target     = tgt_q;
  assign out_o.word_out   = wout_q;
  assign out_o.char_count = cnt_q;
  assign out_o.toggle_out = tog_q;
  assign out_o.last       = last_q;

  a_halt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.cmd == CMD_EXEC) && halt_q)
      |=> (out_o.valid && (out_o.kind == K_HALT) && out_o.last))
    else $error("halted step did not give a halted item");

  a_print_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.ready && !out_o.last) |=> !in_i.ready)
    else $error("new command taken in the middle of a print");

  a_pc_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pc_q <= MEM_LIM))
    else $error("program counter beyond memory end");

  a_init_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready && (in_i.cmd == CMD_INIT))
      |=> ((pc_q == '0) && !tog_q && !halt_q && (gen_q == SPACES)))
    else $error("init did not clear the registers");

endmodule

`default_nettype wire

// File: tb/tb.sv
`timescale 1ns / 100ps
// Self-checking bench for four_char_word_machine_core_unit: a queue-fed command driver,
// a result monitor and an in-bench model of the word machine, under varied idling.
// Depends on fcwm_pkg, fcwm_in_if / fcwm_out_if and the core unit.

module tb;
  import fcwm_pkg::*;

  localparam int unsigned NWORDS      = MEM_WORDS_DEF;
  localparam int unsigned NPRINT      = PRINT_WORDS_DEF;
  localparam int unsigned N_RANDOM    = 500;
  localparam int unsigned HOLD_AT     = 80;
  localparam int unsigned HOLD_LEN    = 300;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned DRAIN       = 12;
  localparam int unsigned MAX_REPORTS = 20;

  typedef struct packed {
    cmd_e              cmd;
    logic [ADDR_W-1:0] addr;
    logic [WORD_W-1:0] word;
  } cmd_item_t;

  typedef struct packed {
    kind_e             kind;
    logic [ADDR_W-1:0] target;
    logic [WORD_W-1:0] word;
    logic [CNT_W-1:0]  cnt;
    logic              tog;
    logic              last;
  } resp_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  fcwm_in_if  in_bus ();
  fcwm_out_if out_bus ();

  four_char_word_machine_core_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  always #4 clk_i = ~clk_i;

  cmd_item_t   cmd_q[$];
  resp_t       resp_due_q[$];
  int unsigned n_total;
  int unsigned n_loaded;
  int unsigned n_fail;
  int unsigned phase;
  int unsigned hold_left;
  bit          hold_done;
  int unsigned idle_run;

  // model state
  logic [WORD_W-1:0] m_mem [NWORDS];
  logic [WORD_W-1:0] m_ir;
  logic [WORD_W-1:0] m_gr;
  logic [ADDR_W-1:0] m_pc;
  logic              m_tog;
  logic              m_halt;

  function automatic bit roll(int unsigned pct);
    return $urandom_range(99) < pct;
  endfunction

  function automatic int unsigned idle_pct(bit rx, int unsigned ph);
    case (ph)
      1: return rx ? 0 : 45;
      2: return rx ? 45 : 0;
      3: return 25;
      default: return 0;
    endcase
  endfunction

  function automatic void queue_cmd(cmd_e c, int unsigned a, logic [WORD_W-1:0] w);
    cmd_item_t it;
    it.cmd  = c;
    it.addr = ADDR_W'(a);
    it.word = w;
    cmd_q.push_back(it);
  endfunction

  function automatic logic [WORD_W-1:0] card_word();
    logic [WORD_W-1:0] w;
    w = SPACES;
    case ($urandom_range(2))
      0: w = SPACES;
      1: begin
        for (int i = 0; i < 4; i++) begin
          case ($urandom_range(3))
            0: w[31-8*i -: 8] = CH_UNDER;
            1: w[31-8*i -: 8] = CH_SPACE;
            2: w[31-8*i -: 8] = CH_C;
            default: w[31-8*i -: 8] = CH_B;
          endcase
        end
      end
      default: w = $urandom;
    endcase
    return w;
  endfunction

  function automatic void mdl_clear();
    for (int i = 0; i < NWORDS; i++) m_mem[i] = SPACES;
    m_ir   = SPACES;
    m_gr   = SPACES;
    m_pc   = '0;
    m_tog  = 1'b0;
    m_halt = 1'b0;
  endfunction

  function automatic void due(kind_e k, int unsigned t, logic [WORD_W-1:0] w,
                              int unsigned c, logic l);
    resp_t r;
    r.kind   = k;
    r.target = ADDR_W'(t);
    r.word   = w;
    r.cnt    = CNT_W'(c);
    r.tog    = m_tog;
    r.last   = l;
    resp_due_q.push_back(r);
  endfunction

  function automatic int unsigned chars_before_under(logic [WORD_W-1:0] w);
    int unsigned n;
    n = 0;
    while (n < 4 && w[31-8*n -: 8] != CH_UNDER) n++;
    return n;
  endfunction

  function automatic void machine_step();
    logic [7:0]  c0, c1, d2, d3;
    int unsigned a;
    bit          addr_op;
    if (m_halt) begin
      due(K_HALT, 0, '0, 0, 1'b1);
      return;
    end
    if (m_pc >= NWORDS) begin
      due(K_ERR, 0, '0, 0, 1'b1);
      return;
    end
    m_ir = m_mem[m_pc];
    m_pc = m_pc + 1'b1;
    {c0, c1, d2, d3} = m_ir;
    if (c0 == CH_H && c1 == CH_SPACE) begin
      m_halt = 1'b1;
      due(K_HALT, 0, '0, 0, 1'b1);
      return;
    end
    addr_op = (c1 == CH_D && (c0 == CH_G || c0 == CH_P)) ||
              (c1 == CH_R && (c0 == CH_L || c0 == CH_S || c0 == CH_C)) ||
              (c0 == CH_B && c1 == CH_T);
    if (!addr_op) begin
      due(K_DONE, 0, '0, 0, 1'b1);
      return;
    end
    if (d2 < CH_ZERO || d2 > CH_NINE || d3 < CH_ZERO || d3 > CH_NINE) begin
      due(K_ERR, 0, '0, 0, 1'b1);
      return;
    end
    a = 10 * (int'(d2) - int'(CH_ZERO)) + (int'(d3) - int'(CH_ZERO));
    if (c0 == CH_P) begin
      if (a + NPRINT > NWORDS) begin
        due(K_ERR, 0, '0, 0, 1'b1);
      end else begin
        for (int i = 0; i < NPRINT; i++)
          due(K_PRINT, a + i, m_mem[a+i], chars_before_under(m_mem[a+i]), i == NPRINT - 1);
      end
      return;
    end
    if (a >= NWORDS) begin
      due(K_ERR, 0, '0, 0, 1'b1);
      return;
    end
    if (c0 == CH_G) begin
      due(K_REQ, a, '0, 0, 1'b1);
      return;
    end
    if (c0 == CH_L) begin
      m_gr = m_mem[a];
    end else if (c0 == CH_S) begin
      m_mem[a] = m_gr;
    end else if (c0 == CH_C) begin
      m_tog = (m_gr == m_mem[a]);
    end else if (m_tog) begin
      m_pc  = ADDR_W'(a);
      m_tog = 1'b0;
    end
    due(K_DONE, 0, '0, 0, 1'b1);
  endfunction

  function automatic void machine_apply(cmd_e c, logic [ADDR_W-1:0] a, logic [WORD_W-1:0] w);
    case (c)
      CMD_WRITE: begin
        if (a >= NWORDS) begin
          due(K_ERR, 0, '0, 0, 1'b1);
        end else begin
          m_mem[a] = w;
          due(K_DONE, 0, '0, 0, 1'b1);
        end
      end
      CMD_EXEC: machine_step();
      CMD_START: begin
        m_pc   = '0;
        m_halt = 1'b0;
        due(K_DONE, 0, '0, 0, 1'b1);
      end
      default: begin
        mdl_clear();
        due(K_DONE, 0, '0, 0, 1'b1);
      end
    endcase
  endfunction

  // command driver
  always @(posedge clk_i or negedge rst_ni) begin
    cmd_item_t   nxt;
    int unsigned nph;
    if (!rst_ni) begin
      in_bus.valid   <= 1'b0;
      in_bus.cmd     <= CMD_WRITE;
      in_bus.address <= '0;
      in_bus.word_in <= '0;
      n_loaded       <= 0;
      phase          <= 0;
    end else begin
      if (in_bus.valid && in_bus.ready)
        machine_apply(cmd_e'(in_bus.cmd), in_bus.address, in_bus.word_in);
      if (!in_bus.valid || in_bus.ready) begin
        if (cmd_q.size() != 0 && !roll(idle_pct(1'b0, phase))) begin
          nxt = cmd_q.pop_front();
          in_bus.valid   <= 1'b1;
          in_bus.cmd     <= nxt.cmd;
          in_bus.address <= nxt.addr;
          in_bus.word_in <= nxt.word;
          nph = ((n_loaded + 1) * 4) / n_total;
          phase    <= (nph > 3) ? 3 : nph;
          n_loaded <= n_loaded + 1;
        end else begin
          in_bus.valid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off so the core backs up onto its input
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && n_loaded >= HOLD_AT) begin
      hold_left <= HOLD_LEN;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // result monitor
  always @(posedge clk_i or negedge rst_ni) begin
    resp_t got;
    resp_t want;
    if (!rst_ni) begin
      out_bus.ready <= 1'b0;
    end else begin
      if (out_bus.valid && out_bus.ready) begin
        got.kind   = kind_e'(out_bus.kind);
        got.target = out_bus.target;
        got.word   = out_bus.word_out;
        got.cnt    = out_bus.char_count;
        got.tog    = out_bus.toggle_out;
        got.last   = out_bus.last;
        if (resp_due_q.size() == 0) begin
          n_fail++;
          if (n_fail <= MAX_REPORTS)
            $display("%0t: unexpected item, kind %0d target %0d word %h", $time,
                     got.kind, got.target, got.word);
        end else begin
          want = resp_due_q.pop_front();
          if (got !== want) begin
            n_fail++;
            if (n_fail <= MAX_REPORTS) begin
              $write("%0t: exp/act kind %0d/%0d target %0d/%0d word %h/%h ", $time,
                     want.kind, got.kind, want.target, got.target, want.word, got.word);
              $display("count %0d/%0d toggle %b/%b last %b/%b",
                       want.cnt, got.cnt, want.tog, got.tog, want.last, got.last);
            end
          end
        end
      end
      out_bus.ready <= (hold_left == 0) && !roll(idle_pct(1'b1, phase));
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if (!rst_ni || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
      idle_run <= 0;
    end else if (idle_run >= STALL_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_run <= idle_run + 1;
    end
  end

  initial begin
    int unsigned n_dir, plen, pick, tgt, nstep, base;
    logic [15:0] op, digs;
    logic [7:0]  bad;
    rst_ni         = 1'b0;
    in_bus.valid   = 1'b0;
    in_bus.cmd     = CMD_WRITE;
    in_bus.address = '0;
    in_bus.word_in = '0;
    out_bus.ready  = 1'b0;
    n_fail         = 0;
    idle_run       = 0;
    mdl_clear();

    // directed: range errors, every opcode, jump, print, past-end, bad digit, halt
    queue_cmd(CMD_INIT, 127, 32'hFFFF_FFFF);
    queue_cmd(CMD_WRITE, 127, 32'hFFFF_FFFF);
    queue_cmd(CMD_WRITE, NWORDS, 32'h0000_0000);
    queue_cmd(CMD_WRITE, 95, "A_BC");
    queue_cmd(CMD_WRITE, 0, "LR95");
    queue_cmd(CMD_WRITE, 1, "CR95");
    queue_cmd(CMD_WRITE, 2, "BT98");
    queue_cmd(CMD_WRITE, 98, "PD90");
    queue_cmd(CMD_WRITE, 99, "GD99");
    queue_cmd(CMD_START, 0, '0);
    repeat (6) queue_cmd(CMD_EXEC, 0, '0);
    queue_cmd(CMD_WRITE, 0, "SR50");
    queue_cmd(CMD_WRITE, 1, "BT:5");
    queue_cmd(CMD_WRITE, 2, "PD91");
    queue_cmd(CMD_WRITE, 3, "H 12");
    queue_cmd(CMD_START, 0, '0);
    repeat (5) queue_cmd(CMD_EXEC, 0, '0);
    n_dir = cmd_q.size();

    // random: mostly loaded programs that are then run, some noise in between
    while (cmd_q.size() < n_dir + N_RANDOM) begin
      if (roll(80)) begin
        if ($urandom_range(3) == 0) queue_cmd(CMD_INIT, $urandom_range(127), $urandom);
        plen = $urandom_range(3, 12);
        for (int i = 0; i < plen; i++) begin
          pick = $urandom_range(19);
          tgt  = $urandom_range(40, 69);
          case (pick)
            0, 1, 2, 3, 15: op = {CH_L, CH_R};
            4, 5:           op = {CH_S, CH_R};
            6, 7, 8, 16:    op = {CH_C, CH_R};
            9, 10: begin
              op  = {CH_B, CH_T};
              tgt = roll(80) ? $urandom_range(0, 11) : $urandom_range(85, 99);
            end
            11: begin
              op  = {CH_G, CH_D};
              tgt = $urandom_range(99);
            end
            12, 13: begin
              op  = {CH_P, CH_D};
              tgt = roll(85) ? $urandom_range(NWORDS - NPRINT) : $urandom_range(91, 99);
            end
            14:      op = {CH_H, CH_SPACE};
            default: op = 16'($urandom);
          endcase
          digs = {8'(CH_ZERO + tgt / 10), 8'(CH_ZERO + tgt % 10)};
          if (roll(8)) begin
            bad = 8'(CH_NINE + 1 + $urandom_range(245));
            if ($urandom_range(1) != 0) digs[15:8] = bad;
            else digs[7:0] = bad;
          end
          queue_cmd(CMD_WRITE, i, {op, digs});
        end
        repeat ($urandom_range(4)) queue_cmd(CMD_WRITE, $urandom_range(40, 69), card_word());
        queue_cmd(CMD_START, $urandom_range(127), $urandom);
        nstep = $urandom_range(plen, plen + 16);
        repeat (nstep) queue_cmd(CMD_EXEC, $urandom_range(127), $urandom);
        if (roll(40)) begin
          base = $urandom_range(40, 60);
          for (int i = 0; i < NPRINT; i++) queue_cmd(CMD_WRITE, base + i, card_word());
        end
      end else begin
        repeat ($urandom_range(1, 5))
          queue_cmd(cmd_e'($urandom_range(3)), $urandom_range(127), $urandom);
      end
    end
    n_total = cmd_q.size();

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    while (cmd_q.size() != 0 || in_bus.valid || resp_due_q.size() != 0) @(negedge clk_i);
    repeat (DRAIN) @(negedge clk_i);

    if (n_fail == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule

// File: four_char_word_machine_core_unit.f
src/fcwm_pkg.sv
src/fcwm_if.sv
src/fcwm_mem.sv
src/four_char_word_machine_core_unit.sv
tb/tb.sv
